@@ sv/cad2d_pkg.sv @@
// Package: shared types and constants for the closest approach block.
package cad2d_pkg;
	localparam int unsigned KIND_W = 2;
	typedef enum logic [KIND_W-1:0] {
		CASE_STILL = 2'd0,
		CASE_PAST  = 2'd1,
		CASE_AHEAD = 2'd2
	} case_t;
endpackage

@@ sv/cad2d_if.sv @@
// Interfaces: input and result channels with valid/ready handshake.
interface cad2d_in_if #(parameter int COORD_WIDTH = 16) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] first_pos_x;
	logic signed [COORD_WIDTH-1:0] first_pos_y;
	logic signed [COORD_WIDTH-1:0] first_vel_x;
	logic signed [COORD_WIDTH-1:0] first_vel_y;
	logic signed [COORD_WIDTH-1:0] second_pos_x;
	logic signed [COORD_WIDTH-1:0] second_pos_y;
	logic signed [COORD_WIDTH-1:0] second_vel_x;
	logic signed [COORD_WIDTH-1:0] second_vel_y;
	modport source (output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
		second_pos_x, second_pos_y, second_vel_x, second_vel_y, input ready);
	modport sink (input valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
		second_pos_x, second_pos_y, second_vel_x, second_vel_y, output ready);
endinterface

interface cad2d_out_if #(parameter int COORD_WIDTH = 16) ();
	logic valid;
	logic ready;
	logic [COORD_WIDTH:0] approach_distance;
	cad2d_pkg::case_t case_taken;
	modport source (output valid, approach_distance, case_taken, input ready);
	modport sink (input valid, approach_distance, case_taken, output ready);
endinterface

@@ sv/cad2d_div_cell.sv @@
// Restoring divider cell: one quotient bit per stage.
module cad2d_div_cell #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [NW-1:0] num_in,
	input  logic [DW:0]   rem_in,
	input  logic [DW-1:0] den_in,
	input  logic [QW-1:0] quo_in,
	input  logic [DW-1:0] side_in,
	input  logic [1:0]    kind_in,
	output logic          valid_out,
	output logic [NW-1:0] num_out,
	output logic [DW:0]   rem_out,
	output logic [DW-1:0] den_out,
	output logic [QW-1:0] quo_out,
	output logic [DW-1:0] side_out,
	output logic [1:0]    kind_out
);
	logic [DW+1:0] shifted;
	logic [DW+1:0] diff;
	logic          take;

	always_comb begin
		shifted = {rem_in, num_in[NW-1]};
		diff    = shifted - {2'b00, den_in};
		take    = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out  <= {num_in[NW-2:0], 1'b0};
			rem_out  <= take ? diff[DW:0] : shifted[DW:0];
			den_out  <= den_in;
			quo_out  <= {quo_in[QW-2:0], take};
			side_out <= side_in;
			kind_out <= kind_in;
		end
	end
endmodule

@@ sv/cad2d_sqrt_cell.sv @@
// Integer square root cell: one root bit per stage.
module cad2d_sqrt_cell #(
	parameter int NW = 64,
	parameter int RW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [NW-1:0] rad_in,
	input  logic [RW+1:0] rem_in,
	input  logic [RW-1:0] root_in,
	input  logic [1:0]    kind_in,
	output logic          valid_out,
	output logic [NW-1:0] rad_out,
	output logic [RW+1:0] rem_out,
	output logic [RW-1:0] root_out,
	output logic [1:0]    kind_out
);
	logic [RW+1:0] shifted;
	logic [RW+1:0] trial;
	logic          take;

	always_comb begin
		shifted = {rem_in[RW-1:0], rad_in[NW-1:NW-2]};
		trial   = {root_in, 2'b01};
		take    = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out  <= {rad_in[NW-3:0], 2'b00};
			rem_out  <= take ? shifted - trial : shifted;
			root_out <= {root_in[RW-2:0], take};
			kind_out <= kind_in;
		end
	end
endmodule

@@ sv/closest_approach_distance_2d.sv @@
// Top level: closest point of approach of two movers in the plane.
// Channel in_ch carries one encounter per item: positions and velocities of
// two movers, signed fixed point. Channel out_ch returns one item per input:
// approach_distance, the floored least future separation, and case_taken
// (still, approach past, approach ahead).
// One item is accepted every cycle unless the chain holds. The item passes
// a front end of five stages (differences, squares and products, sums and
// case select, partial products of cross^2, their sum), then a row of
// 2*W+2 divider cells, one quotient bit each, then a row of W+1 square root
// cells, one root bit each, and an output register, W = COORD_WIDTH.
// The whole chain advances together; when out_ch stalls with a result waiting
// in the output register the chain holds and in_ch ready drops.
// Reset clears all valid bits; no item is in flight afterward.
module closest_approach_distance_2d #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input logic clk,
	input logic arst_n,
	cad2d_in_if.sink   in_ch,
	cad2d_out_if.source out_ch
);
	localparam int W  = COORD_WIDTH;
	localparam int DW = 2*W + 3;
	localparam int NW = 4*W + 4;
	localparam int ND = 2*W + 2;
	localparam int RW = W + 1;
	localparam int NR = RW;
	localparam int SW = 2*RW;

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	logic v_s1, v_s2, v_s3;
	logic signed [W:0] rx_s1, ry_s1, vx_s1, vy_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= {in_ch.second_pos_x[W-1], in_ch.second_pos_x}
				- {in_ch.first_pos_x[W-1], in_ch.first_pos_x};
			ry_s1 <= {in_ch.second_pos_y[W-1], in_ch.second_pos_y}
				- {in_ch.first_pos_y[W-1], in_ch.first_pos_y};
			vx_s1 <= {in_ch.second_vel_x[W-1], in_ch.second_vel_x}
				- {in_ch.first_vel_x[W-1], in_ch.first_vel_x};
			vy_s1 <= {in_ch.second_vel_y[W-1], in_ch.second_vel_y}
				- {in_ch.first_vel_y[W-1], in_ch.first_vel_y};
		end
	end

	logic signed [2*W+1:0] rxx_s2, ryy_s2, vxx_s2, vyy_s2, rxvx_s2, ryvy_s2, rxvy_s2, ryvx_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			rxx_s2  <= rx_s1 * rx_s1;
			ryy_s2  <= ry_s1 * ry_s1;
			vxx_s2  <= vx_s1 * vx_s1;
			vyy_s2  <= vy_s1 * vy_s1;
			rxvx_s2 <= rx_s1 * vx_s1;
			ryvy_s2 <= ry_s1 * vy_s1;
			rxvy_s2 <= rx_s1 * vy_s1;
			ryvx_s2 <= ry_s1 * vx_s1;
		end
	end

	// stage 3: sums, case pick, |cross|
	logic [DW-1:0] r2_c, v2_c;
	logic signed [DW-1:0] dot_c, crs_c;
	logic [DW-1:0] acr_c;
	cad2d_pkg::case_t kind_c;
	always_comb begin
		r2_c  = DW'(rxx_s2) + DW'(ryy_s2);
		v2_c  = DW'(vxx_s2) + DW'(vyy_s2);
		dot_c = DW'(rxvx_s2) + DW'(ryvy_s2);
		crs_c = DW'(rxvy_s2) - DW'(ryvx_s2);
		acr_c = crs_c[DW-1] ? DW'(-crs_c) : DW'(crs_c);
		if (v2_c == '0) begin
			kind_c = cad2d_pkg::CASE_STILL;
		end else if (dot_c > 0) begin
			kind_c = cad2d_pkg::CASE_PAST;
		end else begin
			kind_c = cad2d_pkg::CASE_AHEAD;
		end
	end

	logic [DW-1:0] acr_s3, v2_s3, r2_s3;
	logic [1:0] kind_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			acr_s3  <= acr_c;
			v2_s3   <= (kind_c == cad2d_pkg::CASE_AHEAD) ? v2_c : DW'(1);
			r2_s3   <= r2_c;
			kind_s3 <= kind_c;
		end
	end

	// |cross|^2: the square of the DW-bit |cross| is built from three partial products
	localparam int HW = (DW + 1) / 2;
	logic [HW-1:0] al_c, ah_c;
	assign al_c = acr_s3[HW-1:0];
	assign ah_c = HW'(acr_s3 >> HW);
	logic [2*HW-1:0] ll_s4, lh_s4, hh_s4;
	logic [DW-1:0] v2_s4, r2_s4;
	logic [1:0] kind_s4;
	logic v_s4, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s4   <= al_c * al_c;
			lh_s4   <= al_c * ah_c;
			hh_s4   <= ah_c * ah_c;
			v2_s4   <= v2_s3;
			r2_s4   <= r2_s3;
			kind_s4 <= kind_s3;
		end
	end

	logic [NW-1:0] num_s5;
	logic [DW-1:0] v2_s5, r2_s5;
	logic [1:0] kind_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			num_s5  <= NW'(ll_s4) + (NW'(lh_s4) << (HW + 1)) + (NW'(hh_s4) << (2*HW));
			v2_s5   <= v2_s4;
			r2_s5   <= r2_s4;
			kind_s5 <= kind_s4;
		end
	end

	// divider row; quotient < 2^(2W+2), so the top 2W+2 bits of num give zero quotient
	logic [ND:0]   dv;
	logic [NW-1:0] dn [ND+1];
	logic [DW:0]   dr [ND+1];
	logic [DW-1:0] dd [ND+1];
	logic [ND-1:0] dq [ND+1];
	logic [DW-1:0] ds [ND+1];
	logic [1:0]    dk [ND+1];
	assign dv[0] = v_s5;
	assign dn[0] = num_s5 << (NW - ND);
	assign dr[0] = (DW+1)'(num_s5 >> ND);
	assign dd[0] = v2_s5;
	assign dq[0] = '0;
	assign ds[0] = r2_s5;
	assign dk[0] = kind_s5;

	for (genvar i = 0; i < ND; i++) begin : g_div
		cad2d_div_cell #(.NW(NW), .DW(DW), .QW(ND)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(dv[i]), .num_in(dn[i]), .rem_in(dr[i]), .den_in(dd[i]),
			.quo_in(dq[i]), .side_in(ds[i]), .kind_in(dk[i]),
			.valid_out(dv[i+1]), .num_out(dn[i+1]), .rem_out(dr[i+1]),
			.den_out(dd[i+1]), .quo_out(dq[i+1]), .side_out(ds[i+1]), .kind_out(dk[i+1])
		);
	end

	logic [SW-1:0] rad_c;
	assign rad_c = (dk[ND] == cad2d_pkg::CASE_AHEAD) ? SW'(dq[ND]) : SW'(ds[ND]);

	logic [NR:0]   sv;
	logic [SW-1:0] sr [NR+1];
	logic [RW+1:0] sm [NR+1];
	logic [RW-1:0] so [NR+1];
	logic [1:0]    sk [NR+1];
	assign sv[0] = dv[ND];
	assign sr[0] = rad_c;
	assign sm[0] = '0;
	assign so[0] = '0;
	assign sk[0] = dk[ND];

	for (genvar j = 0; j < NR; j++) begin : g_sqrt
		cad2d_sqrt_cell #(.NW(SW), .RW(RW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(sv[j]), .rad_in(sr[j]), .rem_in(sm[j]), .root_in(so[j]),
			.kind_in(sk[j]),
			.valid_out(sv[j+1]), .rad_out(sr[j+1]), .rem_out(sm[j+1]),
			.root_out(so[j+1]), .kind_out(sk[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= sv[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.approach_distance <= so[NR];
			out_ch.case_taken        <= cad2d_pkg::case_t'(sk[NR]);
		end
	end
endmodule
